// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the tensor/ciphertext index map.
// No dependencies; define SYNTH to compile the assertions out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/tcim_pkg.sv =====
// Types and constants of the tensor/ciphertext index map.
// No dependencies; used by tcim_cfg, tcim_map, the top level and the testbench.
package tcim_pkg;

    // Configuration port
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_LOG_DEGREE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOG_HEADS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOG_TOKENS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOG_HEAD_DIM = 2'd3;

    // Register reset values
    localparam logic [4:0] RST_LOG_DEGREE   = 5'd16;
    localparam logic [3:0] RST_LOG_HEADS    = 4'd2;
    localparam logic [3:0] RST_LOG_TOKENS   = 4'd7;
    localparam logic [3:0] RST_LOG_HEAD_DIM = 4'd8;

    // Flat offset width, also the limit on log_heads + log_head_dim + log_tokens
    localparam int FLAT_W = 24;

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_RANGE  = 2'd1;
    localparam logic [1:0] ST_CONFIG = 2'd2;

    // Function codes
    localparam logic [1:0] FN_T2C = 2'd0;
    localparam logic [1:0] FN_C2T = 2'd1;
    localparam logic [1:0] FN_T2S = 2'd2;
    localparam logic [1:0] FN_S2T = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [14:0] in_head;
        logic [14:0] in_channel;
        logic [14:0] in_token;
        logic [7:0]  in_ct;
        logic [15:0] in_index;
        logic        in_imag;
    } item_t;

    typedef struct packed {
        logic [14:0]       out_head;
        logic [14:0]       out_channel;
        logic [14:0]       out_token;
        logic [7:0]        out_ct;
        logic [15:0]       out_index;
        logic              out_imag;
        logic [FLAT_W-1:0] flat_offset;
        logic [1:0]        status;
    } result_t;

    // Configuration as seen by the datapath, with derived layout sizes
    typedef struct packed {
        logic [4:0] ld;
        logic [3:0] lh;
        logic [3:0] lt;
        logic [3:0] lc;
        logic [4:0] cpc;
        logic [4:0] nct;
        logic       bad;
    } cfg_t;

endpackage

// ===== rtl/tcim_stream_if.sv =====
// Valid/ready stream interface carrying one payload of type T per transaction.
// No dependencies; the payload type is given by the instantiating level.
interface tcim_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/tensor_ciphertext_index_map.sv =====
// Top level of the tensor/ciphertext index map: input register, map logic, result register.
// Depends on tcim_pkg, tcim_stream_if, tcim_cfg, tcim_map and assert_macros.svh.
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+-----------------------------
//  item     | in  | valid / ready       | tcim_pkg::item_t
//  result   | out | valid / ready       | tcim_pkg::result_t
//  cfg      | in  | cfg_we (no ready)   | cfg_index, cfg_data
//
// One transaction per cycle is accepted while no stalled result holds the stages; it is
// registered in the input stage, mapped, and its result registered in the result stage.
// Two register stages set the rate; each advances if empty or if the next one advances.
// item.ready follows result.ready combinationally: a stalled result holds both stages.
// Reset clears both stage valids and loads the configuration defaults.
`include "assert_macros.svh"
module tensor_ciphertext_index_map #(
    parameter int MAX_LOG_DEGREE      = 16,
    parameter int MAX_LOG_CIPHERTEXTS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tcim_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tcim_pkg::CFG_W-1:0]     cfg_data,
    tcim_stream_if.sink                    item,
    tcim_stream_if.source                  result
);
    import tcim_pkg::*;

    cfg_t    cfg;
    result_t map_res;

    logic    s1_valid_reg, s1_valid_next;
    item_t   s1_item_reg;
    logic    s2_valid_reg, s2_valid_next;
    result_t s2_res_reg;
    logic    s1_free, s2_free, accept;

    tcim_cfg #(
        .MAX_LOG_DEGREE      (MAX_LOG_DEGREE),
        .MAX_LOG_CIPHERTEXTS (MAX_LOG_CIPHERTEXTS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tcim_map #(
        .MAX_LOG_DEGREE (MAX_LOG_DEGREE)
    ) u_map (
        .cfg  (cfg),
        .item (s1_item_reg),
        .res  (map_res)
    );

    // Stage flow control
    assign s2_free    = !s2_valid_reg || result.ready;
    assign s1_free    = !s1_valid_reg || s2_free;
    assign accept     = item.valid && s1_free;
    assign item.ready = s1_free;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s2_valid_next = s2_valid_reg;
        if (s2_free)
        begin
            s2_valid_next = s1_valid_reg;
        end
        if (s1_free)
        begin
            s1_valid_next = item.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= item.data;
        end
        if (s2_free && s1_valid_reg)
        begin
            s2_res_reg <= map_res;
        end
    end

    assign result.valid = s2_valid_reg;
    assign result.data  = s2_res_reg;

    // Checks
    `ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, accept, s1_valid_reg, "accepted transaction lost at input stage")
    `ASSERT_NEXT(a_s1_holds, clk, rst_n, s1_valid_reg && !s2_free, s1_valid_reg && $stable(s1_item_reg), "input stage changed while stalled")
    `ASSERT_IMPL(a_status_code, clk, rst_n, result.valid, result.data.status == ST_OK || result.data.status == ST_RANGE || result.data.status == ST_CONFIG, "undefined status code")
    `ASSERT_IMPL(a_error_clears, clk, rst_n, result.valid && result.data.status != ST_OK, result.data.flat_offset == '0 && result.data.out_index == '0 && result.data.out_channel == '0, "error result carries data")

endmodule

// ===== rtl/tcim_cfg.sv =====
// Configuration registers and layout consistency check.
// Depends on tcim_pkg.
module tcim_cfg #(
    parameter int MAX_LOG_DEGREE      = 16,
    parameter int MAX_LOG_CIPHERTEXTS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tcim_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcim_pkg::CFG_W-1:0]      cfg_data,
    output tcim_pkg::cfg_t                  cfg
);
    import tcim_pkg::*;

    localparam logic [5:0] MAX_LD  = 6'(MAX_LOG_DEGREE);
    localparam logic [4:0] MAX_NCT = 5'(MAX_LOG_CIPHERTEXTS);

    logic [4:0] ld_reg, ld_next;
    logic [3:0] lh_reg, lh_next;
    logic [3:0] lt_reg, lt_next;
    logic [3:0] lc_reg, lc_next;
    logic [4:0] sum_ht;
    logic [5:0] sum_all;
    logic [4:0] cpc;
    logic [4:0] nct;

    // Register writes; unused indexes are ignored
    always_comb
    begin
        ld_next = ld_reg;
        lh_next = lh_reg;
        lt_next = lt_reg;
        lc_next = lc_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_LOG_DEGREE:   ld_next = cfg_data;
                REG_LOG_HEADS:    lh_next = cfg_data[3:0];
                REG_LOG_TOKENS:   lt_next = cfg_data[3:0];
                REG_LOG_HEAD_DIM: lc_next = cfg_data[3:0];
                default:          ld_next = ld_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ld_reg <= RST_LOG_DEGREE;
            lh_reg <= RST_LOG_HEADS;
            lt_reg <= RST_LOG_TOKENS;
            lc_reg <= RST_LOG_HEAD_DIM;
        end
        else
        begin
            ld_reg <= ld_next;
            lh_reg <= lh_next;
            lt_reg <= lt_next;
            lc_reg <= lc_next;
        end
    end

    // Derived sizes; a wrapped value only appears when an earlier check already fails
    assign sum_ht  = {1'b0, lh_reg} + {1'b0, lt_reg};
    assign sum_all = {2'b00, lh_reg} + {2'b00, lt_reg} + {2'b00, lc_reg};
    assign cpc     = ld_reg - sum_ht;
    assign nct     = {1'b0, lc_reg} - cpc;

    always_comb
    begin
        cfg.ld  = ld_reg;
        cfg.lh  = lh_reg;
        cfg.lt  = lt_reg;
        cfg.lc  = lc_reg;
        cfg.cpc = cpc;
        cfg.nct = nct;
        cfg.bad = (ld_reg == 5'd0) || ({1'b0, ld_reg} > MAX_LD) || (sum_ht > ld_reg)
               || (cpc > {1'b0, lc_reg}) || (nct > MAX_NCT) || (sum_all > 6'(FLAT_W));
    end

endmodule

// ===== rtl/tcim_map.sv =====
// Index translation between tensor positions and coefficient/slot positions.
// Depends on tcim_pkg; purely combinational, one item per evaluation.
module tcim_map #(
    parameter int MAX_LOG_DEGREE = 16
) (
    input  tcim_pkg::cfg_t    cfg,
    input  tcim_pkg::item_t   item,
    output tcim_pkg::result_t res
);
    import tcim_pkg::*;

    localparam int         CW    = MAX_LOG_DEGREE;
    localparam logic [5:0] CW_P1 = 6'(MAX_LOG_DEGREE + 1);

    logic          fwd;
    logic          slot;
    logic [31:0]   hd32, ch32, tk32, ct32, ix32;
    logic [4:0]    sh_ht;
    logic [4:0]    ldm1;
    logic [5:0]    rev_sh;
    logic [31:0]   mask_cpc, mask_lh, mask_lt;
    logic [31:0]   coeff_f, coeff_top, coeff_i;
    logic [CW-1:0] rev_in, rev_out;
    logic [31:0]   rev_q;
    logic          fwd_err, inv_err;
    logic [31:0]   head_v, chan_v, tok_v, oct_v, oidx_v, flat_v;
    logic          oimag_v;

    assign fwd  = ~item.func[0];
    assign slot = item.func[1];

    assign hd32 = 32'(item.in_head);
    assign ch32 = 32'(item.in_channel);
    assign tk32 = 32'(item.in_token);
    assign ct32 = 32'(item.in_ct);
    assign ix32 = 32'(item.in_index);

    assign sh_ht    = {1'b0, cfg.lh} + {1'b0, cfg.lt};
    assign ldm1     = cfg.ld - 5'd1;
    assign rev_sh   = CW_P1 - {1'b0, cfg.ld};
    assign mask_cpc = ~(32'hFFFF_FFFF << cfg.cpc);
    assign mask_lh  = ~(32'hFFFF_FFFF << cfg.lh);
    assign mask_lt  = ~(32'hFFFF_FFFF << cfg.lt);

    // Tensor position to coefficient: channel-in-ciphertext, head, token
    assign coeff_f   = ((ch32 & mask_cpc) << sh_ht) | (hd32 << cfg.lt) | tk32;
    assign coeff_top = coeff_f >> ldm1;

    // Shared bit reversal over the low log_degree-1 bits
    assign rev_in = fwd ? coeff_f[CW-1:0] : ix32[CW-1:0];
    always_comb
    begin
        for (int j = 0; j < CW; j++)
        begin
            rev_out[j] = rev_in[CW-1-j];
        end
    end
    assign rev_q = 32'(rev_out) >> rev_sh;

    // Coefficient from coefficient index or slot plus imaginary flag
    assign coeff_i = slot ? (rev_q | (32'(item.in_imag) << ldm1)) : ix32;

    // Range checks
    assign fwd_err = (|(hd32 >> cfg.lh)) || (|(ch32 >> cfg.lc)) || (|(tk32 >> cfg.lt));
    assign inv_err = (|(ct32 >> cfg.nct))
                  || (slot ? (|(ix32 >> ldm1)) : (|(ix32 >> cfg.ld)));

    // Field selection per direction
    always_comb
    begin
        if (fwd)
        begin
            head_v  = hd32;
            chan_v  = ch32;
            tok_v   = tk32;
            oct_v   = ch32 >> cfg.cpc;
            oidx_v  = slot ? rev_q : coeff_f;
            oimag_v = slot & coeff_top[0];
        end
        else
        begin
            head_v  = (coeff_i >> cfg.lt) & mask_lh;
            chan_v  = (ct32 << cfg.cpc) + (coeff_i >> sh_ht);
            tok_v   = coeff_i & mask_lt;
            oct_v   = ct32;
            oidx_v  = ix32;
            oimag_v = slot & item.in_imag;
        end
    end

    assign flat_v = (((head_v << cfg.lc) | chan_v) << cfg.lt) | tok_v;

    // Result with status; any error clears every other field
    always_comb
    begin
        res = '0;
        if (cfg.bad)
        begin
            res.status = ST_CONFIG;
        end
        else if (fwd ? fwd_err : inv_err)
        begin
            res.status = ST_RANGE;
        end
        else
        begin
            res.out_head    = head_v[14:0];
            res.out_channel = chan_v[14:0];
            res.out_token   = tok_v[14:0];
            res.out_ct      = oct_v[7:0];
            res.out_index   = oidx_v[15:0];
            res.out_imag    = oimag_v;
            res.flat_offset = flat_v[FLAT_W-1:0];
            res.status      = ST_OK;
        end
    end

endmodule

// ===== sim/tb_tensor_ciphertext_index_map.sv =====
// Self-checking testbench of tensor_ciphertext_index_map: directed and random transactions.
// Depends on tcim_pkg, tcim_stream_if and the RTL of the block; reads no files.
module tb_tensor_ciphertext_index_map;

    import tcim_pkg::*;

    localparam int MAX_LOG_DEG  = 16;
    localparam int MAX_LOG_CTS  = 8;
    localparam int RANDOM_ITEMS = 1900;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int NUM_FIXED    = 13;

    // Layout predictor and store of outstanding expected maps
    class index_map_scoreboard;
        int unsigned ld, lh, lt, lc;
        result_t     pending_maps[$];
        int          errors;

        function new();
            ld = RST_LOG_DEGREE;
            lh = RST_LOG_HEADS;
            lt = RST_LOG_TOKENS;
            lc = RST_LOG_HEAD_DIM;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_LOG_DEGREE:   ld = data;
                REG_LOG_HEADS:    lh = data[3:0];
                REG_LOG_TOKENS:   lt = data[3:0];
                REG_LOG_HEAD_DIM: lc = data[3:0];
                default: ;
            endcase
        endfunction

        function longint unsigned low_mask(int unsigned n);
            return (64'd1 << n) - 64'd1;
        endfunction

        function longint unsigned reverse_bits(longint unsigned v, int unsigned n);
            longint unsigned r;
            r = 0;
            for (int unsigned i = 0; i < n; i++)
                r = (r << 1) | ((v >> i) & 64'd1);
            return r;
        endfunction

        // Layout sizes that cannot be packed, or a flat offset that does not fit
        function bit layout_bad();
            return ld == 0 || ld > MAX_LOG_DEG || lh + lt > ld ||
                   ld - lh - lt > lc || lc - (ld - lh - lt) > MAX_LOG_CTS ||
                   lh + lc + lt > FLAT_W;
        endfunction

        function result_t map_position(item_t it);
            longint unsigned head, chan, tok, ct, idx, cpc, nct, coeff, oct, oidx, oimag;
            result_t r;
            r = '0;
            head = it.in_head;
            chan = it.in_channel;
            tok  = it.in_token;
            ct   = it.in_ct;
            idx  = it.in_index;
            if (layout_bad())
            begin
                r.status = ST_CONFIG;
                return r;
            end
            cpc   = ld - lh - lt;
            nct   = lc - cpc;
            oct   = 0;
            oidx  = 0;
            oimag = 0;
            if (it.func == FN_T2C || it.func == FN_T2S)
            begin
                if (head > low_mask(lh) || chan > low_mask(lc) || tok > low_mask(lt))
                begin
                    r.status = ST_RANGE;
                    return r;
                end
                oct   = chan >> cpc;
                coeff = ((chan & low_mask(cpc)) << (lh + lt)) | (head << lt) | tok;
                if (it.func == FN_T2C)
                    oidx = coeff;
                else
                begin
                    oimag = (coeff >> (ld - 1)) & 64'd1;
                    oidx  = reverse_bits(coeff & low_mask(ld - 1), ld - 1);
                end
            end
            else
            begin
                // Coefficient or slot back to the tensor position
                if (ct > low_mask(nct) ||
                    (it.func == FN_C2T && idx > low_mask(ld)) ||
                    (it.func == FN_S2T && idx > low_mask(ld - 1)))
                begin
                    r.status = ST_RANGE;
                    return r;
                end
                if (it.func == FN_C2T)
                    coeff = idx;
                else
                begin
                    coeff = reverse_bits(idx, ld - 1) | (longint'(it.in_imag) << (ld - 1));
                    oimag = it.in_imag;
                end
                oct  = ct;
                oidx = idx;
                tok  = coeff & low_mask(lt);
                head = (coeff >> lt) & low_mask(lh);
                chan = (ct << cpc) + (coeff >> (lt + lh));
            end
            r.out_head    = head[14:0];
            r.out_channel = chan[14:0];
            r.out_token   = tok[14:0];
            r.out_ct      = oct[7:0];
            r.out_index   = oidx[15:0];
            r.out_imag    = oimag[0];
            r.flat_offset = FLAT_W'((((head << lc) | chan) << lt) | tok);
            r.status      = ST_OK;
            return r;
        endfunction

        function void note_item(item_t it);
            pending_maps.push_back(map_position(it));
        endfunction

        function void check_field(string name, longint unsigned want, longint unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_maps.size() == 0)
            begin
                $error("result transaction with nothing outstanding");
                errors++;
                return;
            end
            want = pending_maps.pop_front();
            check_field("out_head", want.out_head, got.out_head);
            check_field("out_channel", want.out_channel, got.out_channel);
            check_field("out_token", want.out_token, got.out_token);
            check_field("out_ct", want.out_ct, got.out_ct);
            check_field("out_index", want.out_index, got.out_index);
            check_field("out_imag", want.out_imag, got.out_imag);
            check_field("flat_offset", want.flat_offset, got.flat_offset);
            check_field("status", want.status, got.status);
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    tcim_stream_if #(.T(item_t))   item_if ();
    tcim_stream_if #(.T(result_t)) result_if ();

    index_map_scoreboard sb = new();

    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    // ld, lh, lt, lc: extremes of the layout and each kind of inconsistency
    logic [4:0] fixed_cfg [NUM_FIXED][4] = '{
        '{5'd16, 5'd15, 5'd0,  5'd9},
        '{5'd1,  5'd0,  5'd1,  5'd0},
        '{5'd16, 5'd0,  5'd15, 5'd9},
        '{5'd16, 5'd0,  5'd1,  5'd15},
        '{5'd0,  5'd2,  5'd7,  5'd8},
        '{5'd17, 5'd2,  5'd7,  5'd8},
        '{5'd31, 5'd15, 5'd15, 5'd15},
        '{5'd8,  5'd5,  5'd4,  5'd4},
        '{5'd16, 5'd0,  5'd0,  5'd12},
        '{5'd10, 5'd2,  5'd2,  5'd15},
        '{5'd8,  5'h13, 5'h14, 5'h12},
        '{5'd1,  5'd0,  5'd0,  5'd0},
        '{5'd8,  5'd3,  5'd4,  5'd4}
    };

    tensor_ciphertext_index_map #(
        .MAX_LOG_DEGREE      (MAX_LOG_DEG),
        .MAX_LOG_CIPHERTEXTS (MAX_LOG_CTS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_if),
        .result    (result_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random back-pressure, or a long hold-off when one is requested
    initial
    begin
        result_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                result_if.ready <= 1'b0;
            end
            else
                result_if.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Transaction monitors on both channels
    always @(posedge clk)
    begin
        if (rst_n && item_if.valid && item_if.ready)
            sb.note_item(item_if.data);
        if (rst_n && result_if.valid && result_if.ready)
            sb.check_result(result_if.data);
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb_tensor_ciphertext_index_map: errors");
            $finish;
        end
    end

    function automatic item_t make_item(logic [1:0] func, int head, int chan, int tok,
                                        int ct, int idx, bit imag);
        item_t it;
        it.func       = func;
        it.in_head    = 15'(head);
        it.in_channel = 15'(chan);
        it.in_token   = 15'(tok);
        it.in_ct      = 8'(ct);
        it.in_index   = 16'(idx);
        it.in_imag    = imag;
        return it;
    endfunction

    // Mostly in range with the edges favoured; now and then just past or anywhere
    function automatic logic [15:0] pick_index(longint unsigned lim, bit stray);
        if (stray || $urandom_range(0, 23) == 0)
            return $urandom_range(0, 1) ? 16'(lim + 1) : 16'($urandom);
        case ($urandom_range(0, 3))
            0: return 16'd0;
            1: return 16'(lim);
            default: return 16'($urandom & lim);
        endcase
    endfunction

    function automatic item_t random_item();
        item_t       it;
        bit          stray;
        int unsigned cpc;
        stray = sb.layout_bad();
        cpc   = stray ? 0 : sb.ld - sb.lh - sb.lt;
        it.func       = 2'($urandom_range(0, 3));
        it.in_head    = 15'(pick_index(sb.low_mask(sb.lh), stray));
        it.in_channel = 15'(pick_index(sb.low_mask(sb.lc), stray));
        it.in_token   = 15'(pick_index(sb.low_mask(sb.lt), stray));
        it.in_ct      = 8'(pick_index(sb.low_mask(sb.lc - cpc), stray));
        if (it.func == FN_S2T)
            it.in_index = pick_index(sb.low_mask(sb.ld - 1), stray);
        else
            it.in_index = pick_index(sb.low_mask(sb.ld), stray);
        it.in_imag    = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // Offer one transaction after a random gap and wait for it to be taken
    task automatic send_item(item_t it);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            item_if.valid <= 1'b0;
            @(posedge clk);
        end
        item_if.valid <= 1'b1;
        item_if.data  <= it;
        do
            @(posedge clk);
        while (!item_if.ready);
    endtask

    // Wait until every accepted transaction has come back; the first edge lets the
    // monitor note a transaction taken at the edge the caller woke on
    task automatic drain();
        @(posedge clk);
        while (sb.pending_maps.size() != 0)
            @(posedge clk);
    endtask

    // Let the block drain, then load all four registers
    task automatic load_layout(logic [4:0] ld, logic [4:0] lh, logic [4:0] lt,
                               logic [4:0] lc);
        logic [4:0] vals [4];
        vals = '{ld, lh, lt, lc};
        drain();
        repeat (4) @(posedge clk);
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            sb.write_reg(CFG_IDX_W'(i), vals[i]);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int          sent;
        int          seg;
        int          n;
        int unsigned ld, lh, lt, lc, cpc;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        item_if.valid  = 1'b0;
        item_if.data   = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed transactions on the reset layout: 4 heads, 256 channels, 128 tokens
        send_item(make_item(FN_T2C, 0, 0, 0, 0, 0, 0));
        send_item(make_item(FN_T2C, 3, 255, 127, 255, 65535, 1));
        send_item(make_item(FN_T2C, 4, 0, 0, 0, 0, 0));
        send_item(make_item(FN_T2C, 0, 256, 0, 0, 0, 0));
        send_item(make_item(FN_T2C, 0, 0, 128, 0, 0, 0));
        send_item(make_item(FN_T2C, 32767, 32767, 32767, 0, 0, 0));
        send_item(make_item(FN_T2S, 0, 0, 0, 0, 0, 0));
        send_item(make_item(FN_T2S, 3, 255, 127, 0, 0, 0));
        send_item(make_item(FN_T2S, 1, 5, 9, 0, 0, 0));
        send_item(make_item(FN_T2S, 2, 128, 64, 0, 0, 0));
        send_item(make_item(FN_C2T, 0, 0, 0, 0, 0, 0));
        send_item(make_item(FN_C2T, 32767, 32767, 32767, 1, 65535, 1));
        send_item(make_item(FN_C2T, 0, 0, 0, 2, 0, 0));
        send_item(make_item(FN_C2T, 0, 0, 0, 255, 12345, 0));
        send_item(make_item(FN_S2T, 0, 0, 0, 0, 0, 0));
        send_item(make_item(FN_S2T, 0, 0, 0, 1, 32767, 1));
        send_item(make_item(FN_S2T, 0, 0, 0, 0, 32768, 0));
        send_item(make_item(FN_S2T, 0, 0, 0, 0, 65535, 1));
        send_item(make_item(FN_S2T, 0, 0, 0, 1, 1, 0));
        item_if.valid <= 1'b0;

        // Random phases, each with its own layout and idling pattern
        sent = 0;
        seg  = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (seg < NUM_FIXED)
                load_layout(fixed_cfg[seg][0], fixed_cfg[seg][1],
                            fixed_cfg[seg][2], fixed_cfg[seg][3]);
            else if ($urandom_range(0, 7) == 0)
                load_layout(5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom));
            else
            begin
                // Consistent layout built from the ring degree downwards
                ld  = $urandom_range(1, 16);
                lh  = $urandom_range(0, ld < 15 ? ld : 15);
                lt  = $urandom_range(0, ld - lh < 15 ? ld - lh : 15);
                if (ld - lh - lt > 15)
                    lt = 1;
                cpc = ld - lh - lt;
                lc  = $urandom_range(cpc, cpc + 8 < 15 ? cpc + 8 : 15);
                load_layout(5'(ld), 5'(lh), 5'(lt), 5'(lc));
            end
            case (seg % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 62; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 62; end
                default: begin idle_pct = 11; stall_pct = 11; end
            endcase
            // Long receiver hold-off while the sender keeps offering
            if (seg == 0)
                hold_left = HOLD_CYCLES;
            n = sb.layout_bad() ? 24 : 120;
            repeat (n)
            begin
                send_item(random_item());
                sent++;
            end
            item_if.valid <= 1'b0;
            seg++;
        end

        drain();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending_maps.size() == 0)
            $display("tb_tensor_ciphertext_index_map: clean");
        else
            $display("tb_tensor_ciphertext_index_map: errors");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/tcim_pkg.sv
rtl/tcim_stream_if.sv
rtl/tcim_cfg.sv
rtl/tcim_map.sv
rtl/tensor_ciphertext_index_map.sv
sim/tb_tensor_ciphertext_index_map.sv
